/* rtl/core/mctb_pkg.sv */
// shared types and constants for the multi-channel timer bank
// no dependencies
package mctb_pkg;

  localparam int TIMERS_DEF = 16;
  localparam int ADDR_SLOTS = 16;
  localparam int IN_W       = 48;
  localparam int OUT_W      = 56;

  typedef enum logic [3:0] {
    OP_TICK    = 4'd0,
    OP_CREATE  = 4'd1,
    OP_START   = 4'd2,
    OP_STOP    = 4'd3,
    OP_RESTART = 4'd4,
    OP_DELETE  = 4'd5,
    OP_PAUSE   = 4'd6,
    OP_RESUME  = 4'd7,
    OP_SETPER  = 4'd8,
    OP_QRUN    = 4'd9,
    OP_QREM    = 4'd10,
    OP_QELA    = 4'd11
  } op_t;

  typedef struct packed {
    logic load;
    logic inc;
    logic rd;
    logic calc;
    logic apply;
  } dp_cmd_t;

  typedef struct packed {
    logic is_tick;
  } dp_stat_t;

endpackage

/* rtl/core/multi_channel_timer_bank_unit.sv */
// top level of the multi-channel timer bank
// depends on mctb_pkg, mctb_ctrl, mctb_datapath
//
// channel  dir  bits  fields (low bit first)
// in       in   48    operation[3:0] timer_index[7:4] period[39:8] periodic[40]
// out      out  56    fail[0] new_index[4:1] value[36:5] expired_mask[52:37]
//
// one word in flight at a time; tick bumps the tick counter and scans each slot
// via the shared compare unit (read, calc, apply), other commands run read,
// calc, apply once, then the result waits in the output register until taken
// reset clears tick counter and slot flags at once, no clearing pass
// a stalled output holds off the input side
module multi_channel_timer_bank_unit
  import mctb_pkg::*;
#(
  parameter int TIMERS = TIMERS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,  // operation, timer_index, period, periodic
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata  // fail, new_index, value, expired_mask
);

  localparam int IW = (TIMERS > 1) ? $clog2(TIMERS) : 1;

  dp_cmd_t       cmd;
  dp_stat_t      stat;
  logic [IW-1:0] scan_idx;

  mctb_ctrl #(.TIMERS(TIMERS), .IW(IW)) u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready,
    .stat, .cmd, .scan_idx
  );

  mctb_datapath #(.TIMERS(TIMERS), .IW(IW)) u_dp (
    .clk, .rst_n, .in_tdata, .cmd, .scan_idx, .stat, .out_tdata
  );

  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid)) else $error("input and output open together");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready) else $error("second word taken");

  a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> out_tdata[52:1] == '0)
    else $error("rejected command carries data");

endmodule

/* rtl/core/mctb_ctrl.sv */
// command sequencer of the timer bank: handshakes, slot scan on tick
// depends on mctb_pkg
module mctb_ctrl
  import mctb_pkg::*;
#(
  parameter int TIMERS = TIMERS_DEF,
  parameter int IW     = (TIMERS > 1) ? $clog2(TIMERS) : 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  logic          out_tready,
  input  dp_stat_t      stat,
  output dp_cmd_t       cmd,
  output logic [IW-1:0] scan_idx
);

  typedef enum logic [2:0] {
    S_IDLE, S_INC, S_RD, S_CALC, S_APPLY, S_OUT
  } state_t;

  state_t        state_r, state_nxt;
  logic          tick_r, tick_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic          last;

  assign last       = (idx_r == IW'(TIMERS - 1));
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign scan_idx   = idx_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    tick_nxt  = tick_r;
    idx_nxt   = idx_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          tick_nxt  = stat.is_tick;
          idx_nxt   = '0;
          state_nxt = stat.is_tick ? S_INC : S_RD;
        end
      end
      S_INC: begin
        cmd.inc   = 1'b1;
        state_nxt = S_RD;
      end
      S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_CALC;
      end
      S_CALC: begin
        cmd.calc  = 1'b1;
        state_nxt = S_APPLY;
      end
      S_APPLY: begin
        cmd.apply = 1'b1;
        if (tick_r && !last) begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_RD;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_tready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      tick_r  <= 1'b0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      tick_r  <= tick_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

/* rtl/core/mctb_datapath.sv */
// timer bank datapath: slot flags, period/start/remaining memories, result word
// depends on mctb_pkg
module mctb_datapath
  import mctb_pkg::*;
#(
  parameter int TIMERS = TIMERS_DEF,
  parameter int IW     = (TIMERS > 1) ? $clog2(TIMERS) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IN_W-1:0]  in_tdata,
  input  dp_cmd_t          cmd,
  input  logic [IW-1:0]    scan_idx,
  output dp_stat_t         stat,
  output logic [OUT_W-1:0] out_tdata
);

  localparam int REACH = (TIMERS < ADDR_SLOTS) ? TIMERS : ADDR_SLOTS;

  logic [31:0] per_mem [TIMERS];
  logic [31:0] st_mem  [TIMERS];
  logic [31:0] rm_mem  [TIMERS];

  logic [TIMERS-1:0] used_r, run_r, paus_r, prd_r;
  logic [TIMERS-1:0] used_nxt, run_nxt, paus_nxt, prd_nxt;
  logic [31:0] tick_r;
  logic [3:0]  op_r, idx_r;
  logic [31:0] iper_r;
  logic        imode_r;
  logic [31:0] per_q, st_q, rm_q, e_r, d_r;
  logic        fail_r, fail_nxt;
  logic [3:0]  new_r, new_nxt;
  logic [31:0] val_r, val_nxt;
  logic [15:0] mask_r, mask_nxt;

  logic [IW-1:0] slot, waddr, free_idx;
  logic          ok, u, r, p, free_ok, expd;
  logic          we_per, we_st, we_rm;
  logic [31:0]   wd_per, wd_st, wd_rm, left, emin;

  assign stat.is_tick = (op_t'(in_tdata[3:0]) == OP_TICK);
  assign out_tdata = {3'b000, mask_r, val_r, new_r, fail_r};

  assign slot = (op_t'(op_r) == OP_TICK) ? scan_idx : IW'(idx_r);
  assign ok   = (32'(idx_r) < REACH);
  assign u    = ok && used_r[slot];
  assign r    = run_r[slot];
  assign p    = paus_r[slot];
  assign expd = (e_r >= per_q);
  assign left = per_q - e_r;
  assign emin = (e_r < iper_r) ? e_r : iper_r;

  always_comb begin
    free_ok  = 1'b0;
    free_idx = '0;
    for (int i = REACH - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        free_ok  = 1'b1;
        free_idx = IW'(i);
      end
    end
  end

  always_comb begin
    used_nxt = used_r;
    run_nxt  = run_r;
    paus_nxt = paus_r;
    prd_nxt  = prd_r;
    fail_nxt = fail_r;
    new_nxt  = new_r;
    val_nxt  = val_r;
    mask_nxt = mask_r;
    we_per   = 1'b0;
    we_st    = 1'b0;
    we_rm    = 1'b0;
    wd_per   = iper_r;
    wd_st    = tick_r;
    wd_rm    = 32'd0;
    waddr    = slot;
    if (cmd.apply) begin
      unique case (op_t'(op_r))
        OP_TICK: begin
          if (used_r[slot] && r && !p && expd) begin
            if (32'(scan_idx) < ADDR_SLOTS) mask_nxt[4'(scan_idx)] = 1'b1;
            if (prd_r[slot]) we_st = 1'b1;
            else run_nxt[slot] = 1'b0;
          end
        end
        OP_CREATE: begin
          if (iper_r != 32'd0 && free_ok) begin
            waddr              = free_idx;
            used_nxt[free_idx] = 1'b1;
            run_nxt[free_idx]  = 1'b0;
            paus_nxt[free_idx] = 1'b0;
            prd_nxt[free_idx]  = imode_r;
            we_per             = 1'b1;
            we_st              = 1'b1;
            wd_st              = 32'd0;
            we_rm              = 1'b1;
            new_nxt            = 4'(free_idx);
          end else begin
            fail_nxt = 1'b1;
          end
        end
        OP_START, OP_RESTART: begin
          if (u) begin
            run_nxt[slot]  = 1'b1;
            paus_nxt[slot] = 1'b0;
            we_st          = 1'b1;
            we_rm          = 1'b1;
          end else fail_nxt = 1'b1;
        end
        OP_STOP: begin
          if (u) begin
            run_nxt[slot]  = 1'b0;
            paus_nxt[slot] = 1'b0;
            we_rm          = 1'b1;
          end else fail_nxt = 1'b1;
        end
        OP_DELETE: begin
          if (u) begin
            used_nxt[slot] = 1'b0;
            run_nxt[slot]  = 1'b0;
            paus_nxt[slot] = 1'b0;
          end else fail_nxt = 1'b1;
        end
        OP_PAUSE: begin
          if (u && r && !p) begin
            we_rm          = 1'b1;
            wd_rm          = expd ? 32'd0 : left;
            paus_nxt[slot] = 1'b1;
          end else fail_nxt = 1'b1;
        end
        OP_RESUME: begin
          if (u && r && p) begin
            we_st          = 1'b1;
            wd_st          = tick_r - d_r;
            paus_nxt[slot] = 1'b0;
            we_rm          = 1'b1;
          end else fail_nxt = 1'b1;
        end
        OP_SETPER: begin
          if (u && iper_r != 32'd0) begin
            if (r && !p) begin
              we_st = 1'b1;
              wd_st = tick_r - emin;
            end
            we_per = 1'b1;
          end else fail_nxt = 1'b1;
        end
        OP_QRUN: val_nxt = {31'd0, u && r};
        OP_QREM: begin
          if (u && r) val_nxt = p ? rm_q : (expd ? 32'd0 : left);
        end
        OP_QELA: begin
          if (u && r) val_nxt = p ? d_r : (expd ? per_q : e_r);
        end
        default: fail_nxt = 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
      run_r  <= '0;
      paus_r <= '0;
      prd_r  <= '0;
      tick_r <= '0;
    end else begin
      used_r <= used_nxt;
      run_r  <= run_nxt;
      paus_r <= paus_nxt;
      prd_r  <= prd_nxt;
      if (cmd.inc) tick_r <= tick_r + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_tdata[3:0];
      idx_r   <= in_tdata[7:4];
      iper_r  <= in_tdata[39:8];
      imode_r <= in_tdata[40];
      fail_r  <= 1'b0;
      new_r   <= '0;
      val_r   <= '0;
      mask_r  <= '0;
    end else begin
      fail_r  <= fail_nxt;
      new_r   <= new_nxt;
      val_r   <= val_nxt;
      mask_r  <= mask_nxt;
    end
    if (cmd.rd) begin
      per_q <= per_mem[slot];
      st_q  <= st_mem[slot];
      rm_q  <= rm_mem[slot];
    end
    if (cmd.calc) begin
      e_r <= (st_q == 32'd0) ? 32'hFFFF_FFFF : tick_r - st_q;
      d_r <= per_q - rm_q;
    end
    if (we_per) per_mem[waddr] <= wd_per;
    if (we_st)  st_mem[waddr]  <= wd_st;
    if (we_rm)  rm_mem[waddr]  <= wd_rm;
  end

endmodule
